// ----- design/npc_pkg.sv -----
// Package for the non-overlapping pattern counter.
// Holds shared widths, register index codes, link and control structs and the pattern byte picker.
// Depends on nothing; every other file of the block refers to it by scoped names.
package npc_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int LEN_WIDTH       = 5;
   localparam int BLOCK_WIDTH     = 4;
   localparam int COUNT_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 64;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LOW    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_HIGH   = 2'd2;

   // One window slot as it travels along the chain of cells.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data;
      logic                  valid;
   } link_type;

   // Per-cycle commands shared by every cell.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // What the tally unit needs to know about the current transfer.
   typedef struct packed {
      logic take;        // a real byte was accepted
      logic last;        // the accepted item ends the string
      logic code_mode;   // pattern length is zero: count code points
      logic code_point;  // the byte starts a code point
      logic match;       // the window, including the new byte, equals the pattern
   } tally_ctrl_type;

   // Picks pattern byte k from the two 64-bit pattern registers.
   function automatic logic [BYTE_WIDTH-1:0] pattern_byte(
      input logic [CSR_DATA_WIDTH-1:0] low_bytes,
      input logic [CSR_DATA_WIDTH-1:0] high_bytes,
      input logic [BLOCK_WIDTH-1:0]    k
   );
      logic [CSR_DATA_WIDTH-1:0] word;
      word = k[3] ? high_bytes : low_bytes;
      return word[{k[2:0], 3'b000} +: BYTE_WIDTH];
   endfunction

endpackage

// ----- design/npc_cell.sv -----
// One cell of the byte window chain: holds one byte with its valid flag.
// Compares the byte arriving from its upstream neighbour with its pattern byte.
// Depends on npc_pkg.
module npc_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  npc_pkg::cell_ctrl_type           ctrl,
   input  logic                             active,
   input  logic [npc_pkg::BYTE_WIDTH-1:0]   target,
   input  npc_pkg::link_type                up_link,
   output npc_pkg::link_type                down_link,
   output logic                             hit
);

   npc_pkg::link_type link_ff;
   npc_pkg::link_type link_in;

   // Next content: cleared at the end of a string, otherwise takes the neighbour's slot.
   always_comb begin
      link_in = link_ff;
      if (ctrl.clear) begin
         link_in.valid = 1'b0;
      end else if (ctrl.shift) begin
         link_in = up_link;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
         link_ff.data  <= '0;
      end else begin
         link_ff <= link_in;
      end
   end

   // The slot is checked as it will be after this shift; slots past the pattern always agree.
   assign hit       = !active || (up_link.valid && (up_link.data == target));
   assign down_link = link_ff;

endmodule

// ----- design/npc_tally.sv -----
// Match tally for the non-overlapping pattern counter.
// Keeps the overlap block counter and the saturating running count.
// Depends on npc_pkg.
module npc_tally (
   input  logic                               clock,
   input  logic                               reset,
   input  npc_pkg::tally_ctrl_type            ctrl,
   input  logic [npc_pkg::LEN_WIDTH-1:0]      len_eff,
   output logic [npc_pkg::COUNT_WIDTH-1:0]    count_next
);

   logic [npc_pkg::BLOCK_WIDTH-1:0] blocked_ff;
   logic [npc_pkg::BLOCK_WIDTH-1:0] blocked_in;
   logic [npc_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [npc_pkg::COUNT_WIDTH-1:0] count_in;
   logic                            bump;

   // Decide whether this byte adds to the count and how long later matches stay barred.
   always_comb begin
      bump       = 1'b0;
      blocked_in = blocked_ff;
      if (ctrl.take) begin
         if (ctrl.code_mode) begin
            bump = ctrl.code_point;
         end else if (blocked_ff != '0) begin
            blocked_in = blocked_ff - 1'b1;
         end else if (ctrl.match) begin
            bump       = 1'b1;
            blocked_in = npc_pkg::BLOCK_WIDTH'(len_eff - 1'b1);
         end
      end
      count_next = (bump && (count_ff != '1)) ? count_ff + 1'b1 : count_ff;
      count_in   = count_next;
      // The string ends here, so the next one starts from nothing.
      if (ctrl.last) begin
         count_in   = '0;
         blocked_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
         count_ff   <= '0;
      end else begin
         blocked_ff <= blocked_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ----- design/nonoverlap_pattern_counter_unit.sv -----
// Non-overlapping pattern counter: takes one byte per clock cycle and, in the cycle after the
// transfer of the item marked last, offers the number of non-overlapping, leftmost-first
// matches of the configured pattern (or, with a pattern length of zero, the number of UTF-8
// code points), saturating at all ones. Throughput is one item every cycle; it is set by the
// loop that compares the new byte and the whole window against the pattern in parallel and
// updates the overlap block counter. The result sits in a single output register: while it
// waits untaken, input transfers stall, and a result taken in the same cycle as a new input
// transfer costs no gap. Write configuration only while idle; the block does not enforce it.
// Depends on npc_pkg, npc_cell and npc_tally.
module nonoverlap_pattern_counter_unit #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input byte stream.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [npc_pkg::BYTE_WIDTH-1:0]        req_data_byte,
   input  logic                                  req_byte_present,
   input  logic                                  req_last_item,
   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [npc_pkg::COUNT_WIDTH-1:0]       rsp_occurrence_count,
   // Configuration writes.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [npc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [npc_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   logic [npc_pkg::LEN_WIDTH-1:0]      pattern_length_ff;
   logic [npc_pkg::CSR_DATA_WIDTH-1:0] pattern_low_ff;
   logic [npc_pkg::CSR_DATA_WIDTH-1:0] pattern_high_ff;
   logic [npc_pkg::LEN_WIDTH-1:0]      len_eff;
   logic                               accept;
   logic                               match;
   logic [PATTERN_MAX-1:0]             hits;
   npc_pkg::link_type                  chain [PATTERN_MAX];
   npc_pkg::cell_ctrl_type             cell_ctrl;
   npc_pkg::tally_ctrl_type            tally_ctrl;
   logic [npc_pkg::COUNT_WIDTH-1:0]    count_next;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [npc_pkg::COUNT_WIDTH-1:0]    rsp_count_ff;
   logic [npc_pkg::COUNT_WIDTH-1:0]    rsp_count_in;

   // Configuration registers; an index beyond the list is ignored.
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            npc_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_data[npc_pkg::LEN_WIDTH-1:0];
            end
            npc_pkg::CSR_PATTERN_LOW: begin
               pattern_low_ff <= csr_data;
            end
            npc_pkg::CSR_PATTERN_HIGH: begin
               pattern_high_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // A length above the window is taken as the window size.
   assign len_eff = (pattern_length_ff > npc_pkg::LEN_WIDTH'(PATTERN_MAX)) ?
                    npc_pkg::LEN_WIDTH'(PATTERN_MAX) : pattern_length_ff;

   // Input transfers continue as long as the result register is free or being emptied.
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign cell_ctrl.shift = accept && req_byte_present;
   assign cell_ctrl.clear = accept && req_last_item;

   // The newest byte enters the head of the chain as a valid slot.
   assign chain[0] = '{data: req_data_byte, valid: 1'b1};

   // Window cells: slot j lines up with pattern byte len-1-j.
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      logic                           active;
      logic [npc_pkg::BYTE_WIDTH-1:0] target;

      assign active = (len_eff > npc_pkg::LEN_WIDTH'(j));
      assign target = npc_pkg::pattern_byte(pattern_low_ff, pattern_high_ff,
                         npc_pkg::BLOCK_WIDTH'(len_eff - npc_pkg::LEN_WIDTH'(j) - 1'b1));

      if (j < PATTERN_MAX - 1) begin : g_inner
         npc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .active    (active),
            .target    (target),
            .up_link   (chain[j]),
            .down_link (chain[j+1]),
            .hit       (hits[j])
         );
      end else begin : g_tail
         npc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .active    (active),
            .target    (target),
            .up_link   (chain[j]),
            .down_link (),
            .hit       (hits[j])
         );
      end
   end

   assign match = &hits;

   // Tally of matches or code points.
   assign tally_ctrl.take       = accept && req_byte_present;
   assign tally_ctrl.last       = accept && req_last_item;
   assign tally_ctrl.code_mode  = (len_eff == '0);
   assign tally_ctrl.code_point = (req_data_byte[7:6] != 2'b10);
   assign tally_ctrl.match      = match;

   npc_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tally_ctrl),
      .len_eff    (len_eff),
      .count_next (count_next)
   );

   // Result register: loaded when the last item is transferred, freed when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (accept && req_last_item) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_occurrence_count = rsp_count_ff;

endmodule

// ----- design/npc_checker.sv -----
// Port-level checker for the non-overlapping pattern counter, with its bind statement.
// Watches only the ports of nonoverlap_pattern_counter_unit; depends on npc_pkg.
module npc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_last_item,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [npc_pkg::COUNT_WIDTH-1:0]       rsp_occurrence_count
);

   // A stalled result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_occurrence_count)))
      else $error("stalled result changed or vanished");

   // Every transfer of a last item produces a result in the next cycle.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_item) |=> rsp_valid)
      else $error("no result after the last item of a string");

   // A result only appears after a transfer of a last item.
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_item))
      else $error("result appeared without an ending item");

   // With the result register empty the input side never stalls.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while no result is pending");

endmodule

bind nonoverlap_pattern_counter_unit npc_checker u_npc_checker (.*);

// ----- tb/npc_count_checker.sv -----
// Result checker for the non-overlapping pattern counter: it watches all three channels,
// keeps its own copy of the registers and of the scan state, and compares every result.
// Depends on npc_pkg for widths and register index codes.
`timescale 1ns / 100ps

module npc_count_checker #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [npc_pkg::BYTE_WIDTH-1:0]      req_data_byte,
   input  logic                                req_byte_present,
   input  logic                                req_last_item,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [npc_pkg::COUNT_WIDTH-1:0]     rsp_occurrence_count,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [npc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [npc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  fail_count,
   output int                                  outstanding
);

   // Register copies as last written.
   logic [npc_pkg::LEN_WIDTH-1:0]      length_reg;
   logic [npc_pkg::CSR_DATA_WIDTH-1:0] low_reg;
   logic [npc_pkg::CSR_DATA_WIDTH-1:0] high_reg;

   // Scan state of the string in progress; slot 0 holds the newest byte.
   logic [npc_pkg::BYTE_WIDTH-1:0]     recent_bytes [PATTERN_MAX];
   logic [npc_pkg::LEN_WIDTH-1:0]      seen;
   logic [npc_pkg::BLOCK_WIDTH-1:0]    blocked;
   logic [npc_pkg::COUNT_WIDTH-1:0]    tally;

   logic [npc_pkg::COUNT_WIDTH-1:0]    expected_counts [$];
   int                                 errors = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Pattern byte k must sit in window slot len-1-k.
   function automatic logic pattern_ends_here(input int len);
      logic [2*npc_pkg::CSR_DATA_WIDTH-1:0] pattern;
      logic                                 hit;
      int                                   k;
      pattern = {high_reg, low_reg};
      hit = 1'b1;
      for (k = 0; k < len; k++) begin
         if (recent_bytes[len-1-k] != pattern[8*k +: 8]) hit = 1'b0;
      end
      return hit;
   endfunction

   task automatic clear_scan();
      int k;
      for (k = 0; k < PATTERN_MAX; k++) recent_bytes[k] = '0;
      seen    = '0;
      blocked = '0;
      tally   = '0;
   endtask

   task automatic bump_tally();
      if (tally != '1) tally++;
   endtask

   // One real byte: shift it into the window, then count a code point or a match.
   task automatic scan_byte(input logic [npc_pkg::BYTE_WIDTH-1:0] b);
      int len;
      int k;
      len = (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
      for (k = PATTERN_MAX - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = b;
      if (seen < PATTERN_MAX) seen++;
      if (len == 0) begin
         if (b[7:6] != 2'b10) bump_tally();
      end else if (blocked != '0) begin
         blocked--;
      end else if (seen >= len && pattern_ends_here(len)) begin
         bump_tally();
         blocked = npc_pkg::BLOCK_WIDTH'(len - 1);
      end
   endtask

   always @(posedge clock) begin : watch
      logic [npc_pkg::COUNT_WIDTH-1:0] want;
      if (reset) begin
         length_reg = '0;
         low_reg    = '0;
         high_reg   = '0;
         clear_scan();
         expected_counts.delete();
      end else begin
         // A result transfer is matched before this edge's input can queue a new count.
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               $error("occurrence_count: expected no result, got %0d", rsp_occurrence_count);
               errors++;
            end else begin
               want = expected_counts.pop_front();
               if (rsp_occurrence_count !== want) begin
                  $error("occurrence_count: expected %0d, got %0d", want, rsp_occurrence_count);
                  errors++;
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               npc_pkg::CSR_PATTERN_LENGTH: length_reg = csr_data[npc_pkg::LEN_WIDTH-1:0];
               npc_pkg::CSR_PATTERN_LOW:    low_reg    = csr_data;
               npc_pkg::CSR_PATTERN_HIGH:   high_reg   = csr_data;
               // Indexes past the register list are dropped.
               default: ;
            endcase
         end

         // The string ends with the last item, whether or not it carries a byte.
         if (req_valid && req_ready) begin
            if (req_byte_present) scan_byte(req_data_byte);
            if (req_last_item) begin
               expected_counts.push_back(tally);
               clear_scan();
            end
         end
      end
      fail_count  <= errors;
      outstanding <= expected_counts.size();
   end

endmodule

// ----- tb/tb_nonoverlap_pattern_counter_unit.sv -----
// Top of the non-overlapping pattern counter testbench: clock, reset, strings, register
// writes, result back-pressure and the verdict.
// Depends on npc_pkg, nonoverlap_pattern_counter_unit and npc_count_checker.
`timescale 1ns / 100ps

module tb_nonoverlap_pattern_counter_unit;

   localparam int PATTERN_MAX    = 16;
   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int PHASE_ITEMS    = 110;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TIMEOUT_NS     = 10_000_000;
   localparam logic [npc_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [npc_pkg::BYTE_WIDTH-1:0]      req_data_byte;
   logic                                req_byte_present;
   logic                                req_last_item;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [npc_pkg::COUNT_WIDTH-1:0]     rsp_occurrence_count;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [npc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [npc_pkg::CSR_DATA_WIDTH-1:0]  csr_data;
   int                                  fail_count;
   int                                  outstanding;

   // Stimulus control shared with the result side.
   logic                                 steady;
   logic                                 rush;
   int                                   squeeze_ticket;
   int                                   items_sent;
   logic [npc_pkg::BYTE_WIDTH-1:0]       text_bytes [$];
   logic [2*npc_pkg::CSR_DATA_WIDTH-1:0] pattern_text;
   int                                   active_len;

   nonoverlap_pattern_counter_unit #(.PATTERN_MAX(PATTERN_MAX)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_byte_present     (req_byte_present),
      .req_last_item        (req_last_item),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_occurrence_count (rsp_occurrence_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   npc_count_checker #(.PATTERN_MAX(PATTERN_MAX)) count_check (.*);

   always #(HALF_PERIOD) clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offers one item and returns at the edge of its transfer, with valid still high.
   task automatic send_item(input logic [npc_pkg::BYTE_WIDTH-1:0] b, input logic present,
                            input logic last);
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_byte_present <= present;
      req_last_item    <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (present || last) items_sent++;
   endtask

   task automatic pause_sender();
      int n;
      n = (steady || rush) ? 0 : gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [npc_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [npc_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering and waits until every queued count has been transferred.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all pattern registers; the length word carries random upper bits.
   task automatic load_pattern(input logic [npc_pkg::LEN_WIDTH-1:0] len,
                               input logic [2*npc_pkg::CSR_DATA_WIDTH-1:0] pat);
      logic [npc_pkg::CSR_DATA_WIDTH-1:0] noise;
      noise = {$urandom, $urandom};
      write_csr(npc_pkg::CSR_PATTERN_LOW, pat[npc_pkg::CSR_DATA_WIDTH-1:0]);
      write_csr(npc_pkg::CSR_PATTERN_HIGH,
                pat[2*npc_pkg::CSR_DATA_WIDTH-1:npc_pkg::CSR_DATA_WIDTH]);
      write_csr(npc_pkg::CSR_PATTERN_LENGTH,
                {noise[npc_pkg::CSR_DATA_WIDTH-1:npc_pkg::LEN_WIDTH], len});
      if ($urandom_range(0, 2) == 0) write_csr(CSR_SPARE, ~noise);
      pattern_text = pat;
      active_len   = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
   endtask

   // Builds one string: pattern copies, prefixes and stray bytes, or UTF-8-like text.
   task automatic build_text(input int max_len);
      int target;
      int r;
      int n;
      int k;
      text_bytes.delete();
      target = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, max_len);
      while (text_bytes.size() < target) begin
         r = $urandom_range(0, 99);
         if (active_len == 0) begin
            if (r < 45) begin
               text_bytes.push_back(8'($urandom_range(0, 127)));
            end else if (r < 65) begin
               text_bytes.push_back(8'($urandom_range(128, 191)));
            end else if (r < 90) begin
               n = $urandom_range(1, 3);
               text_bytes.push_back(8'($urandom_range(192, 255)));
               repeat (n) text_bytes.push_back(8'($urandom_range(128, 191)));
            end else begin
               text_bytes.push_back(8'($urandom));
            end
         end else begin
            if (r < 40) begin
               for (k = 0; k < active_len; k++) text_bytes.push_back(pattern_text[8*k +: 8]);
            end else if (r < 60) begin
               n = $urandom_range(1, active_len);
               for (k = 0; k < n; k++) text_bytes.push_back(pattern_text[8*k +: 8]);
            end else if (r < 80) begin
               k = $urandom_range(0, active_len - 1);
               text_bytes.push_back(pattern_text[8*k +: 8]);
            end else begin
               text_bytes.push_back(8'($urandom));
            end
         end
      end
   endtask

   // Sends the built string with stray no-byte items; the end marker may carry no byte.
   task automatic send_text();
      int   i;
      logic end_on_byte;
      end_on_byte = (text_bytes.size() > 0) && ($urandom_range(0, 3) != 0);
      for (i = 0; i < text_bytes.size(); i++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b0);
            pause_sender();
         end
         send_item(text_bytes[i], 1'b1, end_on_byte && (i == text_bytes.size() - 1));
         pause_sender();
      end
      if (!end_on_byte) begin
         send_item(8'($urandom), 1'b0, 1'b1);
         pause_sender();
      end
   endtask

   // Result side: random back-pressure, and a long hold-off on request.
   initial begin : result_side
      int served;
      int hold;
      served    = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_ticket != served) begin
            served++;
            rsp_ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            hold = gap_len() + 1;
            repeat (hold) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int                                   phase;
      int                                   phase_start;
      int                                   len;
      int                                   k;
      logic [npc_pkg::BYTE_WIDTH-1:0]       b0;
      logic [npc_pkg::BYTE_WIDTH-1:0]       b1;
      logic [2*npc_pkg::CSR_DATA_WIDTH-1:0] pat;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_byte_present = 1'b0;
      req_last_item    = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      steady           = 1'b0;
      rush             = 1'b0;
      squeeze_ticket   = 0;
      items_sent       = 0;
      pattern_text     = '0;
      active_len       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Code point mode out of reset: continuation bytes do not count, a no-byte item
      // changes nothing, and an empty string reports zero.
      send_item(8'h00, 1'b1, 1'b0);
      pause_sender();
      send_item(8'h80, 1'b1, 1'b0);
      pause_sender();
      send_item(8'hBF, 1'b1, 1'b0);
      pause_sender();
      send_item(8'h3C, 1'b0, 1'b0);
      pause_sender();
      send_item(8'hC0, 1'b1, 1'b0);
      pause_sender();
      send_item(8'hFF, 1'b1, 1'b1);
      pause_sender();
      send_item(8'h5A, 1'b0, 1'b1);
      wait_idle();

      // A write past the register list, then a repeated-letter pattern where overlapping
      // candidates are barred, and a string shorter than the pattern.
      write_csr(CSR_SPARE, {$urandom, $urandom});
      load_pattern(5'd3, {16{8'h61}});
      repeat (5) begin
         send_item(8'h61, 1'b1, 1'b0);
         pause_sender();
      end
      send_item(8'h61, 1'b1, 1'b1);
      pause_sender();
      send_item(8'h61, 1'b1, 1'b0);
      pause_sender();
      send_item(8'h61, 1'b1, 1'b0);
      pause_sender();
      send_item(8'h00, 1'b0, 1'b1);
      wait_idle();

      // Random phases, each with its own pattern length and content.
      items_sent = 0;
      phase      = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (phase % 12)
            0:       len = 1;
            1:       len = 2;
            2:       len = 3;
            3:       len = PATTERN_MAX;
            4:       len = 31;
            5:       len = 0;
            6:       len = PATTERN_MAX + 1;
            7:       len = 8;
            8:       len = 9;
            9:       len = $urandom_range(4, 15);
            10:      len = $urandom_range(17, 31);
            default: len = $urandom_range(1, 7);
         endcase
         b0 = 8'($urandom);
         b1 = ($urandom_range(0, 1) == 0) ? b0 : 8'($urandom);
         if ($urandom_range(0, 2) == 0) begin
            pat = {$urandom, $urandom, $urandom, $urandom};
         end else begin
            for (k = 0; k < 16; k++) pat[8*k +: 8] = k[0] ? b1 : b0;
         end
         load_pattern(npc_pkg::LEN_WIDTH'(len), pat);
         steady <= (phase % 4 == 1);

         // Short strings back to back while results are held off, so the block fills up.
         if (phase % 6 == 2) begin
            rush = 1'b1;
            squeeze_ticket <= squeeze_ticket + 1;
            repeat (24) begin
               build_text(4);
               send_text();
            end
            rush = 1'b0;
         end

         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            build_text(40);
            send_text();
            if ($urandom_range(0, 24) == 0) wait_idle();
         end
         wait_idle();
         phase++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
